// ===== design/wbtd_pkg.sv =====
// Package: shared constants, codes and controller/datapath types for the word-break unit.
`default_nettype none
package wbtd_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int MAX_WORD   = 32;
	localparam int ALPHABET   = 26;

	localparam int LETTER_W = 5;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_DICT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

	localparam logic ANSWER_ACK  = 1'b0;
	localparam logic ANSWER_TEXT = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic ins1_step;
		logic ins2_init;
		logic ins2_step;
		logic txt_step;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              last;
		logic              word_reject;
		logic              step_done;
		logic              full;
		logic              clr_done;
		logic              out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/wbtd_ifs.sv =====
// Interfaces: input item channel and result channel.
`default_nettype none
interface wbtd_in_if;
	logic                          valid;
	logic                          ready;
	logic [wbtd_pkg::KIND_W-1:0]   kind;
	logic [wbtd_pkg::LETTER_W-1:0] letter;
	logic                          last;
	modport source (output valid, kind, letter, last, input ready);
	modport sink (input valid, kind, letter, last, output ready);
endinterface

interface wbtd_out_if;
	logic                          valid;
	logic                          ready;
	logic                          answer_kind;
	logic                          prefix_ok;
	logic                          is_last;
	logic [wbtd_pkg::STATUS_W-1:0] status;
	modport source (output valid, answer_kind, prefix_ok, is_last, status, input ready);
	modport sink (input valid, answer_kind, prefix_ok, is_last, status, output ready);
endinterface
`default_nettype wire

// ===== design/wbtd_ctrl.sv =====
// Controller: sequences clearing, word insertion, text walks and result transfer.
`default_nettype none
module wbtd_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire wbtd_pkg::stat_t st,
	output wbtd_pkg::cmd_t       cmd
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_INS1  = 3'd2;
	localparam logic [2:0] S_INS2R = 3'd3;
	localparam logic [2:0] S_INS2  = 3'd4;
	localparam logic [2:0] S_TXT   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	// decode next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.accept = acc;
				if (acc) begin
					case (st.kind)
						wbtd_pkg::KIND_DICT: begin
							if (st.last) state_d = st.word_reject ? S_EMIT : S_INS1;
						end
						wbtd_pkg::KIND_TEXT:  state_d = S_TXT;
						wbtd_pkg::KIND_CLEAR: state_d = S_CLR;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_INS1: begin
				cmd.ins1_step = 1'b1;
				if (st.step_done) state_d = st.full ? S_EMIT : S_INS2R;
			end
			S_INS2R: begin
				cmd.ins2_init = 1'b1;
				state_d       = S_INS2;
			end
			S_INS2: begin
				cmd.ins2_step = 1'b1;
				if (st.step_done) state_d = S_EMIT;
			end
			S_TXT: begin
				cmd.txt_step = 1'b1;
				if (st.step_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = st.out_free;
				if (st.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== design/wbtd_datapath.sv =====
// Datapath: trie memory, word buffer, text ring, walk registers and result register.
`default_nettype none
module wbtd_datapath #(
	parameter int NODE_COUNT = wbtd_pkg::NODE_COUNT,
	parameter int MAX_WORD   = wbtd_pkg::MAX_WORD,
	parameter int ALPHABET   = wbtd_pkg::ALPHABET
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [wbtd_pkg::KIND_W-1:0]   in_kind,
	input  wire logic [wbtd_pkg::LETTER_W-1:0] in_letter,
	input  wire logic                          in_last,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic                               out_answer_kind,
	output logic                               out_prefix_ok,
	output logic                               out_is_last,
	output logic [wbtd_pkg::STATUS_W-1:0]      out_status,
	input  wire wbtd_pkg::cmd_t                cmd,
	output wbtd_pkg::stat_t                    st
);

	localparam int LW  = wbtd_pkg::LETTER_W;
	localparam int NW  = $clog2(NODE_COUNT);
	localparam int NTW = $clog2(NODE_COUNT + 1);
	localparam int AW  = $clog2(ALPHABET);
	localparam int IW  = $clog2(MAX_WORD);
	localparam int WLW = $clog2(MAX_WORD + 2);
	localparam int TSW = $clog2(MAX_WORD + 1);

	// trie storage
	logic [NW-1:0] mem_q [NODE_COUNT][ALPHABET];
	logic          leaf_mem_q [NODE_COUNT];
	logic [NW-1:0] row_q [ALPHABET];
	logic          leaf_q;
	logic [NW-1:0] raddr;

	// word and text state
	logic [LW-1:0]  wbuf_q [MAX_WORD];
	logic [WLW-1:0] wlen_q;
	logic           bad_q;
	logic [LW-1:0]  ring_let_q [MAX_WORD];
	logic           ring_brk_q [MAX_WORD];
	logic [IW-1:0]  head_q;
	logic [TSW-1:0] seen_q;
	logic [NTW-1:0] node_total_q;

	// walk state
	logic [NW-1:0]  node_q;
	logic [IW-1:0]  idx_q, len_m1_q, ptr_q, ptr_dec;
	logic [WLW-1:0] k_q;
	logic           pend_q, pbrk_q, last_q;
	logic [NW-1:0]  clr_row_q, clr_end_q;

	// staged and presented result
	logic                          res_kind_q, res_ok_q, res_last_q;
	logic [wbtd_pkg::STATUS_W-1:0] res_status_q;

	logic [LW-1:0]  cur_let;
	logic           let_ok;
	logic [AW-1:0]  let_ix;
	logic [NW-1:0]  child, nxt;
	logic [NTW:0]   need;
	logic           t_found, t_stop;

	assign ptr_dec = (ptr_q == '0) ? IW'(MAX_WORD - 1) : ptr_q - 1'b1;
	assign cur_let = cmd.txt_step ? ring_let_q[ptr_q] : wbuf_q[idx_q];
	assign let_ok  = ({1'b0, cur_let} < (LW + 1)'(ALPHABET));
	assign let_ix  = let_ok ? AW'(cur_let) : '0;
	assign child   = row_q[let_ix];
	assign nxt     = (child == '0) ? node_total_q[NW-1:0] : child;
	assign need    = (NTW + 1)'(node_total_q) + (NTW + 1)'(idx_q) + 1'b1;

	// text walk: pending leaf hit ends it, else stop on bound, bad letter or no child
	assign t_found = pend_q && leaf_q && pbrk_q;
	assign t_stop  = t_found || (k_q > WLW'(MAX_WORD)) ||
		((k_q - 1'b1) > WLW'(seen_q)) || !let_ok || (child == '0);

	// next read row
	always_comb begin
		raddr = '0;
		if (cmd.ins1_step && child != '0) raddr = child;
		if (cmd.ins2_step) raddr = nxt;
		if (cmd.txt_step && !t_stop) raddr = child;
	end

	always_comb begin
		st             = '0;
		st.kind        = in_kind;
		st.last        = in_last;
		st.word_reject = (wlen_q >= WLW'(MAX_WORD)) || bad_q ||
			({1'b0, in_letter} >= (LW + 1)'(ALPHABET));
		st.clr_done    = (clr_row_q == clr_end_q);
		st.out_free    = !out_valid || out_ready;
		st.full        = (child == '0) && (need > (NTW + 1)'(NODE_COUNT));
		if (cmd.ins1_step) st.step_done = (child == '0) || (idx_q == '0);
		if (cmd.ins2_step) st.step_done = (idx_q == '0);
		if (cmd.txt_step)  st.step_done = t_stop;
	end

	// trie memory: row clear, entry write, registered read
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			mem_q[clr_row_q]      <= '{default: '0};
			leaf_mem_q[clr_row_q] <= 1'b0;
		end else if (cmd.ins2_step) begin
			if (child == '0) mem_q[node_q][let_ix] <= nxt;
			if (idx_q == '0) leaf_mem_q[nxt] <= 1'b1;
		end
		row_q  <= mem_q[raddr];
		leaf_q <= leaf_mem_q[raddr];
	end

	// buffers and walk payload
	always_ff @(posedge clk) begin
		if (cmd.accept && in_kind == wbtd_pkg::KIND_DICT) begin
			if (wlen_q < WLW'(MAX_WORD)) wbuf_q[wlen_q[IW-1:0]] <= in_letter;
			idx_q    <= wlen_q[IW-1:0];
			len_m1_q <= wlen_q[IW-1:0];
			last_q   <= 1'b0;
		end
		if (cmd.accept && in_kind == wbtd_pkg::KIND_TEXT) begin
			ring_let_q[head_q] <= in_letter;
			ptr_q  <= head_q;
			k_q    <= WLW'(1);
			pend_q <= 1'b0;
			last_q <= in_last;
		end
		if (cmd.ins1_step) idx_q <= idx_q - 1'b1;
		if (cmd.ins2_init) begin
			idx_q  <= len_m1_q;
			node_q <= '0;
		end
		if (cmd.ins2_step) begin
			idx_q  <= idx_q - 1'b1;
			node_q <= nxt;
		end
		if (cmd.txt_step) begin
			pend_q <= 1'b1;
			pbrk_q <= ((k_q - 1'b1) == WLW'(seen_q)) || ring_brk_q[ptr_dec];
			ptr_q  <= ptr_dec;
			k_q    <= k_q + 1'b1;
			if (t_stop) ring_brk_q[head_q] <= t_found;
		end
		// stage result
		if (cmd.accept) begin
			res_kind_q   <= wbtd_pkg::ANSWER_ACK;
			res_ok_q     <= 1'b0;
			res_last_q   <= 1'b0;
			res_status_q <= wbtd_pkg::STATUS_LONG;
		end
		if (cmd.ins1_step && st.full) res_status_q <= wbtd_pkg::STATUS_FULL;
		if (cmd.ins2_step) res_status_q <= wbtd_pkg::STATUS_OK;
		if (cmd.txt_step && t_stop) begin
			res_kind_q   <= wbtd_pkg::ANSWER_TEXT;
			res_ok_q     <= t_found;
			res_last_q   <= last_q;
			res_status_q <= wbtd_pkg::STATUS_OK;
		end
		if (cmd.emit) begin
			out_answer_kind <= res_kind_q;
			out_prefix_ok   <= res_ok_q;
			out_is_last     <= res_last_q;
			out_status      <= res_status_q;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q       <= '0;
			bad_q        <= 1'b0;
			head_q       <= '0;
			seen_q       <= '0;
			node_total_q <= NTW'(1);
			clr_row_q    <= '0;
			clr_end_q    <= NW'(NODE_COUNT - 1);
			out_valid    <= 1'b0;
		end else begin
			if (cmd.accept && in_kind == wbtd_pkg::KIND_DICT) begin
				if (in_last) begin
					wlen_q <= '0;
					bad_q  <= 1'b0;
				end else begin
					if (wlen_q <= WLW'(MAX_WORD)) wlen_q <= wlen_q + 1'b1;
					if (wlen_q < WLW'(MAX_WORD) &&
						{1'b0, in_letter} >= (LW + 1)'(ALPHABET)) bad_q <= 1'b1;
				end
			end
			if (cmd.accept && in_kind == wbtd_pkg::KIND_CLEAR) begin
				clr_row_q    <= '0;
				clr_end_q    <= NW'(node_total_q - 1'b1);
				node_total_q <= NTW'(1);
				wlen_q       <= '0;
				bad_q        <= 1'b0;
			end
			if (cmd.clr_step && !st.clr_done) clr_row_q <= clr_row_q + 1'b1;
			if (cmd.ins2_step && child == '0) node_total_q <= node_total_q + 1'b1;
			if (cmd.txt_step && t_stop) begin
				head_q <= (head_q == IW'(MAX_WORD - 1)) ? '0 : head_q + 1'b1;
				if (last_q) seen_q <= '0;
				else if (seen_q < TSW'(MAX_WORD)) seen_q <= seen_q + 1'b1;
			end
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== design/word_break_trie_dp_unit.sv =====
// Top level: streaming word-break test over a reversed dictionary trie.
//
//   channel  | dir | payload                                   | transfer
//   in_ch    | in  | kind, letter, last                        | valid & ready
//   out_ch   | out | answer_kind, prefix_ok, is_last, status   | valid & ready
//
// A text letter walks back through the trie: one trie row read per level walked back.
// A finished word takes a fit check walk and an insert walk.
// After reset a clearing pass sweeps all trie rows; a clear item sweeps
// the rows in use. No item is taken meanwhile.
// The result register lets a new item be taken while a result waits; the unit
// stalls only when a second result is ready before the first is taken.
`default_nettype none
module word_break_trie_dp_unit #(
	parameter int NODE_COUNT = wbtd_pkg::NODE_COUNT,
	parameter int MAX_WORD   = wbtd_pkg::MAX_WORD,
	parameter int ALPHABET   = wbtd_pkg::ALPHABET
) (
	input wire logic    clk,
	input wire logic    arst_n,
	wbtd_in_if.sink     in_ch,
	wbtd_out_if.source  out_ch
);

	wbtd_pkg::cmd_t  cmd;
	wbtd_pkg::stat_t st;

	wbtd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	wbtd_datapath #(
		.NODE_COUNT (NODE_COUNT),
		.MAX_WORD   (MAX_WORD),
		.ALPHABET   (ALPHABET)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_kind         (in_ch.kind),
		.in_letter       (in_ch.letter),
		.in_last         (in_ch.last),
		.out_ready       (out_ch.ready),
		.out_valid       (out_ch.valid),
		.out_answer_kind (out_ch.answer_kind),
		.out_prefix_ok   (out_ch.prefix_ok),
		.out_is_last     (out_ch.is_last),
		.out_status      (out_ch.status),
		.cmd             (cmd),
		.st              (st)
	);

endmodule
`default_nettype wire

// ===== design/wbtd_checker.sv =====
// Checker: port-level properties of the word-break unit, bound to the top level.
`default_nettype none
module wbtd_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic                                answer_kind,
	input wire logic                                prefix_ok,
	input wire logic                                is_last,
	input wire logic [wbtd_pkg::STATUS_W-1:0]       status
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({answer_kind, prefix_ok, is_last, status}))
		else $error("stalled result changed");

	// acknowledgements carry no text flags
	a_ack: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && answer_kind == wbtd_pkg::ANSWER_ACK |-> !prefix_ok && !is_last)
		else $error("acknowledgement with text flags");

	// text results carry status ok
	a_txt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && answer_kind == wbtd_pkg::ANSWER_TEXT |-> status == wbtd_pkg::STATUS_OK)
		else $error("text result with nonzero status");

	// status stays within its codes
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == wbtd_pkg::STATUS_OK || status == wbtd_pkg::STATUS_FULL ||
			status == wbtd_pkg::STATUS_LONG)
		else $error("unknown status code");

endmodule

bind word_break_trie_dp_unit wbtd_checker u_wbtd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.answer_kind (out_ch.answer_kind),
	.prefix_ok   (out_ch.prefix_ok),
	.is_last     (out_ch.is_last),
	.status      (out_ch.status)
);
`default_nettype wire
